// ===== rtl/mbet_pkg.sv =====
// Shared types and constants for the escape-time block.
// Holds the fixed-point format, config register codes and the structs
// passed between the front stage, the point queue and the iteration engine.
package mbet_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int STEP_W      = 31;
    localparam int COORD_W     = 12;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // |z|^2 is at most 2^(63-F); the bound 4.0 needs F+3 bits
    localparam int MAG_W = ((PROD_W - FRAC_BITS) > (FRAC_BITS + 3)) ?
                           (PROD_W - FRAC_BITS) : (FRAC_BITS + 3);
    localparam logic [MAG_W-1:0] ESCAPE_BOUND = MAG_W'(4) << FRAC_BITS;

    localparam logic [DATA_W-1:0]  REAL_START_RST = 32'hD800_0000;
    localparam logic [DATA_W-1:0]  IMAG_START_RST = 32'hF000_0000;
    localparam logic [STEP_W-1:0]  REAL_STEP_RST  = 31'h0003_8000;
    localparam logic [STEP_W-1:0]  IMAG_STEP_RST  = 31'h0002_0000;
    localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REAL_START = 3'd0,
        REG_IMAG_START = 3'd1,
        REG_REAL_STEP  = 3'd2,
        REG_IMAG_STEP  = 3'd3,
        REG_ITER_LIMIT = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_UPD  = 2'd2,
        ST_DONE = 2'd3
    } t_eng_state;

    typedef struct packed {
        logic [DATA_W-1:0]  real_start;
        logic [DATA_W-1:0]  imag_start;
        logic [STEP_W-1:0]  real_step;
        logic [STEP_W-1:0]  imag_step;
        logic [COUNT_W-1:0] iter_limit;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] cr;
        logic [DATA_W-1:0] ci;
    } t_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/mbet_front.sv =====
// Front stage: accepts pixel requests and maps them to the point c.
// Depends on mbet_pkg; feeds mbet_queue.
module mbet_front
    import mbet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_pixel_column,
    input  logic [COORD_W-1:0] i_pixel_row,
    input  t_queue_status      i_qstat,
    output logic               o_push,
    output t_point             o_point
);

    logic   r_valid;
    t_point r_point;
    t_point n_point;
    logic [COORD_W+STEP_W-1:0] w_re_off;
    logic [COORD_W+STEP_W-1:0] w_im_off;

    assign w_re_off = {{STEP_W{1'b0}}, i_pixel_column} * {{COORD_W{1'b0}}, i_cfg.real_step};
    assign w_im_off = {{STEP_W{1'b0}}, i_pixel_row} * {{COORD_W{1'b0}}, i_cfg.imag_step};

    // coordinates wrap in the data width
    assign n_point.cr = i_cfg.real_start + w_re_off[DATA_W-1:0];
    assign n_point.ci = i_cfg.imag_start + w_im_off[DATA_W-1:0];

    assign o_push  = r_valid && !i_qstat.full;
    assign o_ready = !r_valid || !i_qstat.full;
    assign o_point = r_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_point <= n_point;
        end
    end

endmodule

// ===== rtl/mbet_queue.sv =====
// Short queue of mapped points between the front stage and the engine.
// Depends on mbet_pkg; register-based, head read combinationally.
module mbet_queue
    import mbet_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_point        i_point,
    input  logic          i_pop,
    output t_point        o_point,
    output t_queue_status o_stat
);

    t_point              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_point      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_point;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full && !i_pop |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/mbet_back.sv =====
// Iteration engine: runs z = z*z + c for one point and holds the count.
// Depends on mbet_pkg; each iteration has a multiply state, then an update state.
module mbet_back
    import mbet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_queue_status      i_qstat,
    input  t_point             i_point,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COUNT_W-1:0] o_iteration_count
);

    t_eng_state r_state;
    t_eng_state n_state;

    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_cr;
    logic signed [DATA_W-1:0] r_ci;
    logic signed [PROD_W-1:0] r_pxx;
    logic signed [PROD_W-1:0] r_pyy;
    logic signed [PROD_W-1:0] r_pxy;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_out_valid;
    logic [COUNT_W-1:0]       r_out_count;

    logic signed [PROD_W-1:0] w_xx;
    logic signed [PROD_W-1:0] w_yy;
    logic signed [PROD_W-1:0] w_xy2;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_escape;
    logic [COUNT_W-1:0]       w_count_inc;
    logic                     w_step;
    logic                     w_load_out;
    logic                     w_out_free;

    assign w_xx        = r_pxx >>> FRAC_BITS;
    assign w_yy        = r_pyy >>> FRAC_BITS;
    assign w_xy2       = r_pxy >>> (FRAC_BITS - 1);
    // squares are non-negative, so the low bits carry the exact sum
    assign w_mag       = w_xx[MAG_W-1:0] + w_yy[MAG_W-1:0];
    assign w_escape    = (w_mag > ESCAPE_BOUND);
    assign w_count_inc = r_count + 1'b1;
    assign w_out_free  = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = (i_cfg.iter_limit == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_escape || (w_count_inc == i_cfg.iter_limit)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        w_step     = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop      = !i_qstat.empty;
            ST_MUL:  ;
            ST_UPD:  w_step     = !w_escape;
            ST_DONE: w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cr    <= i_point.cr;
            r_ci    <= i_point.ci;
            r_x     <= '0;
            r_y     <= '0;
            r_count <= '0;
        end else if (w_step) begin
            r_x     <= w_xx[DATA_W-1:0] - w_yy[DATA_W-1:0] + r_cr;
            r_y     <= w_xy2[DATA_W-1:0] + r_ci;
            r_count <= w_count_inc;
        end
        if (r_state == ST_MUL) begin
            r_pxx <= r_x * r_x;
            r_pyy <= r_y * r_y;
            r_pxy <= r_x * r_y;
        end
        if (w_load_out) begin
            r_out_count <= r_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_iteration_count = r_out_count;

`ifndef ASSERT_OFF
    a_upd_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD |-> $past(r_state) == ST_MUL)
        else $error("update without fresh products");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_count == '0)
        else $error("count not cleared on new point");
`endif

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// Top level of the escape-time block: config registers and the three parts.
// Depends on mbet_pkg, mbet_front, mbet_queue and mbet_back.
//
//   port group   direction  handshake          payload
//   pixel in     in         i_valid / o_ready  i_pixel_column, i_pixel_row
//   count out    out        o_valid / i_ready  o_iteration_count
//   config       in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// A pixel is registered in the front stage, then waits in a four-entry queue.
// The engine pops a point in its idle state, then for each iteration a multiply
// state forms three products and an update state steps z, until the point escapes
// or the limit is reached; a zero limit goes straight to done. The done state loads
// the output. Reset is synchronous, active low, and clears the control state and
// loads the default region. The front keeps accepting pixels while the engine
// works or while a result waits at the output, until the queue and its own register are full.
module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COORD_W-1:0]   i_pixel_column,
    input  logic [COORD_W-1:0]   i_pixel_row,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [COUNT_W-1:0]   o_iteration_count
);

    t_cfg          r_cfg;
    t_point        w_push_point;
    t_point        w_head_point;
    t_queue_status w_qstat;
    logic          w_push;
    logic          w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start <= REAL_START_RST;
            r_cfg.imag_start <= IMAG_START_RST;
            r_cfg.real_step  <= REAL_STEP_RST;
            r_cfg.imag_step  <= IMAG_STEP_RST;
            r_cfg.iter_limit <= ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_REAL_START: r_cfg.real_start <= i_cfg_data;
                REG_IMAG_START: r_cfg.imag_start <= i_cfg_data;
                REG_REAL_STEP:  r_cfg.real_step  <= i_cfg_data[STEP_W-1:0];
                REG_IMAG_STEP:  r_cfg.imag_step  <= i_cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT: r_cfg.iter_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    mbet_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_point        (w_push_point)
    );

    mbet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_point (w_push_point),
        .i_pop   (w_pop),
        .o_point (w_head_point),
        .o_stat  (w_qstat)
    );

    mbet_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_qstat           (w_qstat),
        .i_point           (w_head_point),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_iteration_count (o_iteration_count)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for mandelbrot_escape_time: pixel requests in, iteration counts out.
// Depends on mbet_pkg and the RTL under rtl/; keeps its own fixed-point escape-time predictor.
module tb;
    import mbet_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 600;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_ITER_LIMIT + 1);
    localparam logic signed [PROD_W-1:0] RADIUS_SQ = 64'sd4 <<< FRAC_BITS;

    class escape_scoreboard;
        logic [DATA_W-1:0]  real_start;
        logic [DATA_W-1:0]  imag_start;
        logic [STEP_W-1:0]  real_step;
        logic [STEP_W-1:0]  imag_step;
        logic [COUNT_W-1:0] iter_limit;
        logic [COUNT_W-1:0] counts_due[$];
        int mismatches;
        int checked;

        function new();
            real_start = REAL_START_RST;
            imag_start = IMAG_START_RST;
            real_step  = REAL_STEP_RST;
            imag_step  = IMAG_STEP_RST;
            iter_limit = ITER_LIMIT_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_REAL_START: real_start = data;
                REG_IMAG_START: imag_start = data;
                REG_REAL_STEP:  real_step  = data[STEP_W-1:0];
                REG_IMAG_STEP:  imag_step  = data[STEP_W-1:0];
                REG_ITER_LIMIT: iter_limit = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Iterate z = z*z + c in Q4.28 with 32-bit wrap on every stored value.
        function logic [COUNT_W-1:0] escape_count(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row);
            logic [DATA_W-1:0] cr_u, ci_u;
            logic signed [PROD_W-1:0] cr, ci, x, y, xx, yy, xy2, nx, ny;
            int n;
            cr_u = real_start + DATA_W'(col) * DATA_W'(real_step);
            ci_u = imag_start + DATA_W'(row) * DATA_W'(imag_step);
            cr = PROD_W'($signed(cr_u));
            ci = PROD_W'($signed(ci_u));
            x = '0;
            y = '0;
            n = 0;
            while (n < iter_limit) begin
                xx = (x * x) >>> FRAC_BITS;
                yy = (y * y) >>> FRAC_BITS;
                if (xx + yy > RADIUS_SQ)
                    break;
                xy2 = (x * y) >>> (FRAC_BITS - 1);
                nx = xx - yy + cr;
                ny = xy2 + ci;
                x = PROD_W'($signed(nx[DATA_W-1:0]));
                y = PROD_W'($signed(ny[DATA_W-1:0]));
                n++;
            end
            return COUNT_W'(n);
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
            counts_due.push_back(escape_count(col, row));
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            if (counts_due.size() == 0) begin
                $display("%0t: count with no request pending, expected none, got %0d",
                         $time, got);
                mismatches++;
                return;
            end
            want = counts_due.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: count mismatch, expected %0d, got %0d", $time, want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return counts_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_pixel_column;
    logic [COORD_W-1:0]   i_pixel_row;
    logic                 o_valid;
    logic                 i_ready;
    logic [COUNT_W-1:0]   o_iteration_count;

    escape_scoreboard sb = new();
    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int random_sent = 0;
    int settings    = 0;

    mandelbrot_escape_time dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row       (i_pixel_row),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_iteration_count (o_iteration_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb failed");
        $finish;
    end

    // Count sink: random stalls, plus one long hold-off on request.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_count(o_iteration_count);
    end

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        if (!steady && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row    <= row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(col, row);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic load_region(input logic [DATA_W-1:0] re0, input logic [DATA_W-1:0] im0,
                               input logic [DATA_W-1:0] re_step,
                               input logic [DATA_W-1:0] im_step,
                               input logic [DATA_W-1:0] lim);
        put_reg(REG_REAL_START, re0);
        put_reg(REG_IMAG_START, im0);
        put_reg(REG_REAL_STEP, re_step);
        put_reg(REG_IMAG_STEP, im_step);
        put_reg(REG_ITER_LIMIT, lim);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic poke_spare_regs();
        for (int k = REG_SPARE_FIRST; k < 2 ** CFG_IDX_W; k++)
            put_reg(CFG_IDX_W'(k), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 9) < 2)
            return $urandom_range(0, 1) ? '1 : '0;
        return COORD_W'($urandom);
    endfunction

    task automatic random_phase(input int phase);
        logic [DATA_W-1:0] re0, im0, re_step, im_step;
        int lim, n;
        if (phase % 4 == 3) begin
            re0     = $urandom;
            im0     = $urandom;
            re_step = $urandom;
            im_step = $urandom;
        end else begin
            // window that covers the set, so most pixels iterate for a while
            re0     = REAL_START_RST + $urandom_range(0, 32'h2800_0000);
            im0     = IMAG_START_RST - $urandom_range(0, 32'h0800_0000);
            re_step = $urandom_range(0, 32'h0004_0000);
            im_step = $urandom_range(0, 32'h0004_0000);
        end
        if (phase == 0)
            lim = 8;
        else if (phase == 2 || phase == 6)
            lim = ITER_LIMIT_RST;
        else
            lim = $urandom_range(0, 64);
        n = (lim > 100) ? 10 : $urandom_range(20, 40);
        load_region(re0, im0, re_step, im_step, lim);
        steady = (phase == 4);
        // fill the block while the sink is stalled
        if (phase == 0)
            hold_req = 1'b1;
        repeat (n) begin
            send_pixel(pick_coord(), pick_coord());
            random_sent++;
        end
        wait_results();
        steady = 1'b0;
    endtask

    initial begin
        int phase;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_REAL_START;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_pixel_column <= '0;
        i_pixel_row    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default region: corners, a point deep in the main bulb, the point -0.75
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        send_pixel('0, '1);
        send_pixel(12'd2340, 12'd2048);
        send_pixel(12'd2048, 12'd2048);
        wait_results();

        // zero limit gives a zero count; limit one stops after a single step
        load_region(REAL_START_RST, IMAG_START_RST, REAL_STEP_RST, IMAG_STEP_RST, 0);
        send_pixel(12'd2340, 12'd2048);
        send_pixel('1, '1);
        send_pixel('0, '0);
        wait_results();
        load_region(REAL_START_RST, IMAG_START_RST, REAL_STEP_RST, IMAG_STEP_RST, 1);
        send_pixel(12'd2340, 12'd2048);
        send_pixel('1, '0);
        wait_results();

        // coordinates wrap past the 32-bit range
        load_region(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16);
        send_pixel('1, '1);
        send_pixel(12'd1, '0);
        send_pixel('0, 12'd1);
        send_pixel('0, '0);
        send_pixel('1, 12'd1);
        wait_results();

        // zero steps at the largest limit: origin never escapes, far corner does
        load_region(0, 0, 0, 0, 16'hFFFF);
        send_pixel(12'd1234, 12'd4000);
        wait_results();
        load_region(32'h8000_0000, 32'h2000_0000, 0, 0, 16'hFFFF);
        send_pixel('1, '1);
        send_pixel('0, '0);
        wait_results();

        // writes to unmapped indexes must leave the region alone
        poke_spare_regs();
        send_pixel(12'd77, 12'd3000);
        send_pixel(12'd4000, 12'd5);
        wait_results();

        phase = 0;
        while (random_sent < RANDOM_PIXELS) begin
            random_phase(phase);
            phase++;
        end

        wait_results();
        repeat (20) @(posedge i_clk);
        $display("checked %0d counts over %0d region settings, including wrapped coordinates,",
                 sb.checked, settings);
        $display("zero and full limits, a long sink stall and a stall-free stretch");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
